/* hw/rtl/aff_bnd_pkg.sv */
// ----------------------------------------------------------------------------
// Affine point bounds package
// Shared widths, item kinds and default parameter values for the affine
// point bounds unit and its channel interfaces.
// ----------------------------------------------------------------------------
package aff_bnd_pkg;

  localparam int VALUE_W         = 32;
  localparam int OUT_W           = 32;
  localparam int ROW_W           = 2;
  localparam int MATRIX_ROWS     = 3;
  localparam int COEFS_PER_ROW   = 4;
  localparam int AXES            = 3;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  typedef enum logic [1:0] {
    KIND_CLEAR     = 2'd0,
    KIND_LOAD_ROW  = 2'd1,
    KIND_ADD_POINT = 2'd2,
    KIND_REPORT    = 2'd3
  } kind_t;

endpackage

/* hw/rtl/aff_bnd_if.sv */
// ----------------------------------------------------------------------------
// Affine point bounds channels
// Valid/ready channels for input items and for report results.
// ----------------------------------------------------------------------------
interface aff_bnd_item_if
  import aff_bnd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  kind_t                     kind;
  logic        [ROW_W-1:0]   row;
  logic signed [VALUE_W-1:0] value_x;
  logic signed [VALUE_W-1:0] value_y;
  logic signed [VALUE_W-1:0] value_z;
  logic signed [VALUE_W-1:0] value_w;

  modport source (
    output valid, kind, row, value_x, value_y, value_z, value_w,
    input  ready
  );

  modport sink (
    input  valid, kind, row, value_x, value_y, value_z, value_w,
    output ready
  );
endinterface

interface aff_bnd_result_if
  import aff_bnd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    box_empty;
  logic signed [OUT_W-1:0] low_x;
  logic signed [OUT_W-1:0] low_y;
  logic signed [OUT_W-1:0] low_z;
  logic signed [OUT_W-1:0] high_x;
  logic signed [OUT_W-1:0] high_y;
  logic signed [OUT_W-1:0] high_z;
  logic signed [OUT_W-1:0] mid_x;
  logic signed [OUT_W-1:0] mid_y;
  logic signed [OUT_W-1:0] mid_z;
  logic        [OUT_W-1:0] span;

  modport source (
    output valid, box_empty, low_x, low_y, low_z, high_x, high_y, high_z,
           mid_x, mid_y, mid_z, span,
    input  ready
  );

  modport sink (
    input  valid, box_empty, low_x, low_y, low_z, high_x, high_y, high_z,
           mid_x, mid_y, mid_z, span,
    output ready
  );
endinterface

/* hw/rtl/affine_point_bounds_unit.sv */
// ----------------------------------------------------------------------------
// Affine point bounds unit
// Transforms points by a loaded 3x4 affine matrix and keeps the axis-aligned
// bounding box of the results; report items return corners, center and span.
// ----------------------------------------------------------------------------
// Reports pass the input, multiply, sum, round, report and result registers.
// Throughput: one item per cycle, set by the multiply, sum, round and box
// update stages; input stalls only in reset or while a stage ahead holds a
// report that the full result register cannot take.
// Reset: synchronous; empties the pipeline, clears the box to empty at zero
// and loads the identity matrix.
module affine_point_bounds_unit
  import aff_bnd_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  aff_bnd_item_if.sink     items,
  aff_bnd_result_if.source results
);

  localparam int PROD_W = 2 * VALUE_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SPAN_W = (DIFF_W > OUT_W) ? DIFF_W : OUT_W;
  localparam int EXT_W  = (COORD_WIDTH > OUT_W) ? COORD_WIDTH : OUT_W;

  localparam logic signed [VALUE_W-1:0] COEF_ONE   = VALUE_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]   COORD_MAX  =
    (SUM_W'(1) << (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0]   COORD_MIN  = -(SUM_W'(1) << (COORD_WIDTH - 1));
  localparam logic        [SPAN_W-1:0]  SPAN_LIM   = SPAN_W'({OUT_W{1'b1}});
  localparam logic        [ROW_W-1:0]   ROW_LIMIT  = ROW_W'(MATRIX_ROWS);

  function automatic logic [OUT_W-1:0] to_out(input logic signed [COORD_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[OUT_W-1:0];
  endfunction

  logic signed [VALUE_W-1:0]     coef [MATRIX_ROWS][COEFS_PER_ROW];

  logic                          v1;
  kind_t                         kind1;
  logic signed [VALUE_W-1:0]     val1 [AXES];

  logic                          v2;
  kind_t                         kind2;
  logic signed [PROD_W-1:0]      prod2 [MATRIX_ROWS][AXES];
  logic signed [VALUE_W-1:0]     shift2 [MATRIX_ROWS];

  logic                          v3;
  kind_t                         kind3;
  logic signed [SUM_W-1:0]       sum3 [MATRIX_ROWS];

  logic                          v4;
  kind_t                         kind4;
  logic signed [COORD_WIDTH-1:0] t4 [AXES];

  logic signed [COORD_WIDTH-1:0] box_low [AXES];
  logic signed [COORD_WIDTH-1:0] box_high [AXES];
  logic                          box_empty;

  logic                          v5;
  logic                          empty5;
  logic signed [COORD_WIDTH-1:0] low5 [AXES];
  logic signed [COORD_WIDTH-1:0] high5 [AXES];
  logic        [DIFF_W-1:0]      diff5 [AXES];

  logic                          out_valid;

  logic                          out_free;
  logic                          go5;
  logic                          ready5;
  logic                          retire4;
  logic                          ready4;
  logic                          go3;
  logic                          ready3;
  logic                          go2;
  logic                          ready2;
  logic                          go1;
  logic                          ready1;
  logic                          accept;

  logic signed [SUM_W-1:0]       sum_next [MATRIX_ROWS];
  logic signed [COORD_WIDTH-1:0] t_next [AXES];
  logic        [DIFF_W-1:0]      diff_next [AXES];
  logic signed [COORD_WIDTH-1:0] mid_next [AXES];
  logic        [OUT_W-1:0]       span_next;

  assign out_free = !out_valid || results.ready;
  assign go5      = v5 && out_free;
  assign ready5   = !v5 || out_free;
  assign retire4  = v4 && ((kind4 != KIND_REPORT) || ready5);
  assign ready4   = !v4 || retire4;
  assign go3      = v3 && ready4;
  assign ready3   = !v3 || ready4;
  assign go2      = v2 && ready3;
  assign ready2   = !v2 || ready3;
  assign go1      = v1 && ready2;
  assign ready1   = !v1 || ready2;
  assign accept   = items.valid && ready1 && !rst;

  assign items.ready   = ready1 && !rst;
  assign results.valid = out_valid;

  always_comb begin
    logic signed [SUM_W-1:0]  shifted;
    logic signed [DIFF_W-1:0] hsum;
    logic        [DIFF_W-1:0] dmax;
    logic        [SPAN_W-1:0] dext;
    for (int r = 0; r < MATRIX_ROWS; r++) begin
      sum_next[r] = SUM_W'(prod2[r][0]) + SUM_W'(prod2[r][1]) + SUM_W'(prod2[r][2])
                  + (SUM_W'(shift2[r]) <<< FRAC_BITS) + ROUND_HALF;
    end
    for (int a = 0; a < AXES; a++) begin
      shifted = sum3[a] >>> FRAC_BITS;
      if (shifted > COORD_MAX) begin
        t_next[a] = COORD_MAX[COORD_WIDTH-1:0];
      end else if (shifted < COORD_MIN) begin
        t_next[a] = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
        t_next[a] = shifted[COORD_WIDTH-1:0];
      end
      diff_next[a] = DIFF_W'(DIFF_W'(box_high[a]) - DIFF_W'(box_low[a]));
      hsum         = DIFF_W'(low5[a]) + DIFF_W'(high5[a]);
      mid_next[a]  = hsum[DIFF_W-1:1];
    end
    dmax = diff5[0];
    for (int a = 1; a < AXES; a++) begin
      if (diff5[a] > dmax) begin
        dmax = diff5[a];
      end
    end
    dext      = SPAN_W'(dmax);
    span_next = (dext > SPAN_LIM) ? {OUT_W{1'b1}} : dext[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        for (int k = 0; k < COEFS_PER_ROW; k++) begin
          coef[r][k] <= (r == k) ? COEF_ONE : '0;
        end
      end
    end else if (accept && (items.kind == KIND_LOAD_ROW) && (items.row < ROW_LIMIT)) begin
      coef[items.row][0] <= items.value_x;
      coef[items.row][1] <= items.value_y;
      coef[items.row][2] <= items.value_z;
      coef[items.row][3] <= items.value_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= accept || (v1 && !go1);
      v2        <= go1 || (v2 && !go2);
      v3        <= go2 || (v3 && !go3);
      v4        <= go3 || (v4 && !retire4);
      v5        <= (retire4 && (kind4 == KIND_REPORT)) || (v5 && !go5);
      out_valid <= go5 || (out_valid && !results.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind1   <= items.kind;
      val1[0] <= items.value_x;
      val1[1] <= items.value_y;
      val1[2] <= items.value_z;
    end
    if (go1) begin
      kind2 <= kind1;
      for (int r = 0; r < MATRIX_ROWS; r++) begin
        for (int k = 0; k < AXES; k++) begin
          prod2[r][k] <= coef[r][k] * val1[k];
        end
        shift2[r] <= coef[r][COEFS_PER_ROW-1];
      end
    end
    if (go2) begin
      kind3 <= kind2;
      sum3  <= sum_next;
    end
    if (go3) begin
      kind4 <= kind3;
      t4    <= t_next;
    end
    if (retire4 && (kind4 == KIND_REPORT)) begin
      empty5 <= box_empty;
      low5   <= box_low;
      high5  <= box_high;
      diff5  <= diff_next;
    end
    if (go5) begin
      results.box_empty <= empty5;
      results.low_x     <= to_out(low5[0]);
      results.low_y     <= to_out(low5[1]);
      results.low_z     <= to_out(low5[2]);
      results.high_x    <= to_out(high5[0]);
      results.high_y    <= to_out(high5[1]);
      results.high_z    <= to_out(high5[2]);
      results.mid_x     <= to_out(mid_next[0]);
      results.mid_y     <= to_out(mid_next[1]);
      results.mid_z     <= to_out(mid_next[2]);
      results.span      <= span_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_empty <= 1'b1;
      for (int a = 0; a < AXES; a++) begin
        box_low[a]  <= '0;
        box_high[a] <= '0;
      end
    end else if (retire4) begin
      unique case (kind4)
        KIND_CLEAR: begin
          box_empty <= 1'b1;
          for (int a = 0; a < AXES; a++) begin
            box_low[a]  <= '0;
            box_high[a] <= '0;
          end
        end
        KIND_ADD_POINT: begin
          box_empty <= 1'b0;
          for (int a = 0; a < AXES; a++) begin
            if (box_empty || (t4[a] < box_low[a])) begin
              box_low[a] <= t4[a];
            end
            if (box_empty || (t4[a] > box_high[a])) begin
              box_high[a] <= t4[a];
            end
          end
        end
        KIND_LOAD_ROW, KIND_REPORT: begin
        end
        default: begin
        end
      endcase
    end
  end

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    !box_empty |-> (box_low[0] <= box_high[0]) && (box_low[1] <= box_high[1])
                   && (box_low[2] <= box_high[2]))
    else $error("box corners out of order");

  a_empty_box_zero: assert property (@(posedge clk) disable iff (rst)
    box_empty |-> (box_low[0] == '0) && (box_low[1] == '0) && (box_low[2] == '0)
                  && (box_high[0] == '0) && (box_high[1] == '0) && (box_high[2] == '0))
    else $error("empty box holds nonzero corners");

  a_row_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && (items.kind == KIND_LOAD_ROW) && (items.row < ROW_LIMIT)
    |=> (coef[$past(items.row)][0] == $past(items.value_x))
        && (coef[$past(items.row)][3] == $past(items.value_w)))
    else $error("matrix row not written on load");

  a_report_held: assert property (@(posedge clk) disable iff (rst)
    v5 && !out_free |=> v5 && $stable(empty5))
    else $error("pending report lost while result register is full");

endmodule
